// ----- rtl/cbq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the control store of the cascaded biquad filter.
// No dependencies; every other file imports this package.
package cbq_pkg;

    localparam int HIST_W         = 32;
    localparam int ACC_W          = 64;
    localparam int MODE_W         = 3;
    localparam int MODE_COUNT     = 5;
    localparam int TABLE_SECTIONS = 5;
    localparam int COEF_TAPS      = 5;
    localparam int TABLE_FRAC     = 22;
    localparam logic [MODE_W-1:0] MODE_MAX = 3'd4;

    typedef logic signed [31:0] t_coef_raw;

    // Per section: b0, b1, b2, a1, a2 in Q2.22
    localparam t_coef_raw COEF_TABLE [MODE_COUNT][TABLE_SECTIONS][COEF_TAPS] = '{
        '{ '{  253373,  506745,  253373, -6534459, 3353646 },
           '{  214617,  429234,  214617, -5534958, 2199123 },
           '{  194074,  388149,  194074, -5005159, 1587152 },
           '{  887196,  887196,       0, -2419911,       0 },
           '{       0,       0,       0,        0,       0 } },
        '{ '{  282928,  565856,  282928, -4794008, 1731415 },
           '{       0,       0,       0,        0,       0 },
           '{       0,       0,       0,        0,       0 },
           '{       0,       0,       0,        0,       0 },
           '{       0,       0,       0,        0,       0 } },
        '{ '{  446641,  893282,  446641, -5535543, 3127803 },
           '{  363391,  726782,  363391, -4503764, 1763024 },
           '{  321874,  643747,  321874, -3989208, 1082398 },
           '{ 1138922, 1138922,       0, -1916459,       0 },
           '{       0,       0,       0,        0,       0 } },
        '{ '{ 1621757, 3243513, 1621757,  -665022, 2957744 },
           '{ 1269935, 2539870, 1269935,  -520753, 1406189 },
           '{ 1079097, 2158194, 1079097,  -442498,  564581 },
           '{  982708, 1965417,  982708,  -402972,  139502 },
           '{ 1999440, 1999440,       0,  -195424,       0 } },
        '{ '{  446669,  893337,  446669, -3728355, 1320725 },
           '{       0,       0,       0,        0,       0 },
           '{       0,       0,       0,        0,       0 },
           '{       0,       0,       0,        0,       0 },
           '{       0,       0,       0,        0,       0 } }
    };

    localparam logic [3:0] SECTION_COUNT [MODE_COUNT] = '{4'd4, 4'd1, 4'd4, 4'd5, 4'd1};

    // Multiplier operand; the code doubles as the coefficient tap index
    typedef enum logic [2:0] {
        OPND_U0   = 3'd0,
        OPND_U1   = 3'd1,
        OPND_U2   = 3'd2,
        OPND_H1   = 3'd3,
        OPND_H2   = 3'd4,
        OPND_NONE = 3'd5
    } t_opnd;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } t_acc;

    // Sequencing action of a control word
    typedef enum logic [2:0] {
        SEQ_WAIT,
        SEQ_NEXT,
        SEQ_LOOP,
        SEQ_EMIT,
        SEQ_CLEAR
    } t_seq;

    typedef enum logic [3:0] {
        STEP_WAIT = 4'd0,
        STEP_F0   = 4'd1,
        STEP_F1   = 4'd2,
        STEP_F2   = 4'd3,
        STEP_F3   = 4'd4,
        STEP_F4   = 4'd5,
        STEP_D0   = 4'd6,
        STEP_D1   = 4'd7,
        STEP_WB   = 4'd8,
        STEP_OUT  = 4'd9,
        STEP_CLR  = 4'd10
    } t_step;

    typedef struct packed {
        t_opnd opnd;
        t_acc  acc;
        t_seq  seq;
        t_step target;
    } t_uword;

    typedef struct packed {
        t_opnd opnd;
        t_acc  acc;
        logic  take;
        logic  writeback;
        logic  emit;
        logic  clear;
    } t_ctrl;

    typedef struct packed {
        logic more;
        logic out_free;
    } t_status;

    // Control store: one section is fetch x5, drain x2, write back and loop
    function automatic t_uword rom_word(input t_step s);
        t_uword w;
        case (s)
            STEP_WAIT: w = '{OPND_NONE, ACC_HOLD, SEQ_WAIT,  STEP_CLR};
            STEP_F0:   w = '{OPND_U0,   ACC_HOLD, SEQ_NEXT,  STEP_WAIT};
            STEP_F1:   w = '{OPND_U1,   ACC_HOLD, SEQ_NEXT,  STEP_WAIT};
            STEP_F2:   w = '{OPND_U2,   ACC_LOAD, SEQ_NEXT,  STEP_WAIT};
            STEP_F3:   w = '{OPND_H1,   ACC_ADD,  SEQ_NEXT,  STEP_WAIT};
            STEP_F4:   w = '{OPND_H2,   ACC_ADD,  SEQ_NEXT,  STEP_WAIT};
            STEP_D0:   w = '{OPND_NONE, ACC_SUB,  SEQ_NEXT,  STEP_WAIT};
            STEP_D1:   w = '{OPND_NONE, ACC_SUB,  SEQ_NEXT,  STEP_WAIT};
            STEP_WB:   w = '{OPND_NONE, ACC_HOLD, SEQ_LOOP,  STEP_F0};
            STEP_OUT:  w = '{OPND_NONE, ACC_HOLD, SEQ_EMIT,  STEP_WAIT};
            STEP_CLR:  w = '{OPND_NONE, ACC_HOLD, SEQ_CLEAR, STEP_WAIT};
            default:   w = '{OPND_NONE, ACC_HOLD, SEQ_NEXT,  STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/cbq_if.sv -----
`timescale 1ns / 1ps
// Handshake channels of the cascaded biquad filter: sample requests,
// results and mode register writes. Uses cbq_pkg for the mode width.
interface cbq_in_if #(
    parameter int DATA_WIDTH = 24
);
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic signed [DATA_WIDTH-1:0] sample_in;

    modport source (output valid, kind, sample_in, input ready);
    modport sink   (input valid, kind, sample_in, output ready);
endinterface

interface cbq_out_if #(
    parameter int DATA_WIDTH = 24
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] filtered;
    logic                         saturated;

    modport source (output valid, filtered, saturated, input ready);
    modport sink   (input valid, filtered, saturated, output ready);
endinterface

interface cbq_cfg_if;
    import cbq_pkg::*;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/cbq_seq.sv -----
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control store lookup and jumps.
// Depends on cbq_pkg for the control word, step codes and status struct.
module cbq_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_clear,
    input  cbq_pkg::t_status i_status,
    output cbq_pkg::t_ctrl   o_ctrl,
    output logic             o_in_ready
);
    import cbq_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_step  step_inc;
    t_uword word;

    // Step register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

    // Decode the current word against the datapath status
    always_comb begin
        word        = rom_word(r_step);
        step_inc    = t_step'(r_step + 4'd1);
        n_step      = r_step;
        o_in_ready  = 1'b0;
        o_ctrl      = '0;
        o_ctrl.opnd = word.opnd;
        o_ctrl.acc  = word.acc;
        case (word.seq)
            SEQ_WAIT: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_clear) begin
                        n_step = word.target;
                    end else begin
                        o_ctrl.take = 1'b1;
                        n_step      = step_inc;
                    end
                end
            end
            SEQ_NEXT: begin
                n_step = step_inc;
            end
            SEQ_LOOP: begin
                o_ctrl.writeback = 1'b1;
                n_step = i_status.more ? word.target : step_inc;
            end
            SEQ_EMIT: begin
                if (i_status.out_free) begin
                    o_ctrl.emit = 1'b1;
                    n_step      = word.target;
                end
            end
            SEQ_CLEAR: begin
                if (i_status.out_free) begin
                    o_ctrl.clear = 1'b1;
                    n_step       = word.target;
                end
            end
            default: begin
                n_step = STEP_WAIT;
            end
        endcase
    end

endmodule

// ----- rtl/cbq_datapath.sv -----
`timescale 1ns / 1ps
// Shared multiply-accumulate datapath, filter history and result register.
// Driven by the control word from cbq_seq; depends on cbq_pkg.
module cbq_datapath #(
    parameter int MAX_SECTIONS = 5,
    parameter int DATA_WIDTH   = 24,
    parameter int COEF_WIDTH   = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cbq_pkg::t_ctrl                      i_ctrl,
    input  logic [cbq_pkg::MODE_W-1:0]          i_mode,
    input  logic signed [DATA_WIDTH-1:0]        i_sample,
    input  logic                                i_out_ready,
    output cbq_pkg::t_status                    o_status,
    output logic                                o_out_valid,
    output logic signed [DATA_WIDTH-1:0]        o_filtered,
    output logic                                o_saturated
);
    import cbq_pkg::*;

    localparam int SEC_W     = $clog2(MAX_SECTIONS + 1);
    localparam int SEC_IW    = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int COEF_FRAC = COEF_WIDTH - 2;
    localparam int SH_UP     = (COEF_FRAC >= TABLE_FRAC) ? COEF_FRAC - TABLE_FRAC : 0;
    localparam int SH_DN     = (COEF_FRAC < TABLE_FRAC) ? TABLE_FRAC - COEF_FRAC : 0;
    localparam int PROD_W    = COEF_WIDTH + HIST_W;

    localparam logic signed [39:0]       C_RND  = (40'sd1 <<< SH_DN) >>> 1;
    localparam logic signed [ACC_W-1:0]  HALF   = 64'sd1 <<< (COEF_FRAC - 1);
    localparam logic signed [ACC_W-1:0]  Y_MAX  = 64'sd2147483647;
    localparam logic signed [ACC_W-1:0]  Y_MIN  = -64'sd2147483648;
    localparam logic signed [HIST_W-1:0] D_MAX  = (32'sd1 <<< (DATA_WIDTH - 1)) - 32'sd1;
    localparam logic signed [HIST_W-1:0] D_MIN  = -D_MAX - 32'sd1;

    // Rescale a Q2.22 table entry to the coefficient format, round half up
    function automatic logic signed [COEF_WIDTH-1:0] scale_coef(input t_coef_raw c);
        logic signed [39:0] t;
        t = $signed({{8{c[31]}}, c});
        if (SH_DN == 0) begin
            t = t <<< SH_UP;
        end else begin
            t = (t + C_RND) >>> SH_DN;
        end
        return t[COEF_WIDTH-1:0];
    endfunction

    // History
    logic signed [DATA_WIDTH-1:0] r_ih1, r_ih2;
    logic signed [HIST_W-1:0]     r_sh1 [MAX_SECTIONS];
    logic signed [HIST_W-1:0]     r_sh2 [MAX_SECTIONS];

    // Section operands and sequencing
    logic signed [HIST_W-1:0]     r_u0, r_u1, r_u2, r_last;
    logic [SEC_W-1:0]             r_sec, r_n;
    logic [MODE_W-1:0]            r_msel;

    // Multiply-accumulate pipeline
    logic signed [COEF_WIDTH-1:0] r_coef;
    logic signed [HIST_W-1:0]     r_opnd;
    logic signed [ACC_W-1:0]      r_prod, r_acc;

    // Result register
    logic                         r_out_valid;
    logic signed [DATA_WIDTH-1:0] r_filtered;
    logic                         r_sat;

    logic [SEC_IW-1:0]            sec_idx;
    logic [2:0]                   tab_sec;
    logic [2:0]                   tab_tap;
    logic signed [HIST_W-1:0]     h1, h2, opnd;
    logic signed [PROD_W-1:0]     mul;
    logic signed [ACC_W-1:0]      acc_sh;
    logic signed [HIST_W-1:0]     y;
    logic signed [HIST_W-1:0]     res;
    logic [SEC_W:0]               sec_inc;
    logic [MODE_W-1:0]            msel;
    logic [3:0]                   cnt, cnt_cap;

    assign sec_idx = r_sec[SEC_IW-1:0];
    assign tab_sec = 3'(r_sec);
    assign h1      = r_sh1[sec_idx];
    assign h2      = r_sh2[sec_idx];

    // Operand and coefficient select
    always_comb begin
        tab_tap = 3'(i_ctrl.opnd);
        case (i_ctrl.opnd)
            OPND_U0: opnd = r_u0;
            OPND_U1: opnd = r_u1;
            OPND_U2: opnd = r_u2;
            OPND_H1: opnd = h1;
            OPND_H2: opnd = h2;
            default: begin
                opnd    = '0;
                tab_tap = 3'd0;
            end
        endcase
    end

    assign mul = r_coef * r_opnd;

    // Section output: drop the fraction, clamp to 32 bits
    always_comb begin
        acc_sh = r_acc >>> COEF_FRAC;
        if (acc_sh > Y_MAX) begin
            y = 32'sh7fffffff;
        end else if (acc_sh < Y_MIN) begin
            y = 32'sh80000000;
        end else begin
            y = acc_sh[HIST_W-1:0];
        end
    end

    // Final clip to the data range
    always_comb begin
        if (r_last > D_MAX) begin
            res = D_MAX;
        end else if (r_last < D_MIN) begin
            res = D_MIN;
        end else begin
            res = r_last;
        end
    end

    // Mode decode and section count
    always_comb begin
        msel    = (i_mode > MODE_MAX) ? MODE_MAX : i_mode;
        cnt     = SECTION_COUNT[msel];
        cnt_cap = (cnt > 4'(MAX_SECTIONS)) ? 4'(MAX_SECTIONS) : cnt;
        sec_inc = {1'b0, r_sec} + 1'b1;
    end

    assign o_status.more     = sec_inc < {1'b0, r_n};
    assign o_status.out_free = !r_out_valid || i_out_ready;

    // Advance the multiply-accumulate pipeline
    always_ff @(posedge i_clk) begin
        r_coef <= scale_coef(COEF_TABLE[r_msel][tab_sec][tab_tap]);
        r_opnd <= opnd;
        r_prod <= ACC_W'(mul);
        case (i_ctrl.acc)
            ACC_LOAD: r_acc <= r_prod + HALF;
            ACC_ADD:  r_acc <= r_acc + r_prod;
            ACC_SUB:  r_acc <= r_acc - r_prod;
            default:  r_acc <= r_acc;
        endcase
    end

    // Load a new request or hand the section output on
    always_ff @(posedge i_clk) begin
        if (i_ctrl.take) begin
            r_u0   <= HIST_W'(i_sample);
            r_u1   <= HIST_W'(r_ih1);
            r_u2   <= HIST_W'(r_ih2);
            r_msel <= msel;
        end else if (i_ctrl.writeback) begin
            r_u0   <= y;
            r_u1   <= h1;
            r_u2   <= h2;
            r_last <= y;
        end
    end

    // Section counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec <= '0;
            r_n   <= '0;
        end else if (i_ctrl.take) begin
            r_sec <= '0;
            r_n   <= SEC_W'(cnt_cap);
        end else if (i_ctrl.writeback) begin
            r_sec <= sec_inc[SEC_W-1:0];
        end
    end

    // History: shift on use, zero on reset and on a clear request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_ih1 <= '0;
            r_ih2 <= '0;
            for (int i = 0; i < MAX_SECTIONS; i++) begin
                r_sh1[i] <= '0;
                r_sh2[i] <= '0;
            end
        end else begin
            if (i_ctrl.take) begin
                r_ih1 <= i_sample;
                r_ih2 <= r_ih1;
            end
            if (i_ctrl.writeback) begin
                r_sh1[sec_idx] <= y;
                r_sh2[sec_idx] <= h1;
            end
        end
    end

    // Result register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.emit || i_ctrl.clear) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_filtered <= '0;
            r_sat      <= 1'b0;
        end else if (i_ctrl.emit) begin
            r_filtered <= res[DATA_WIDTH-1:0];
            r_sat      <= (res != r_last);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_filtered  = r_filtered;
    assign o_saturated = r_sat;

endmodule

// ----- rtl/cascaded_biquad_lowpass_core.sv -----
`timescale 1ns / 1ps
// Cascaded biquad low-pass core: sequencer, MAC datapath and mode register.
// A filter request runs its n sections in turn through the single shared
// multiplier pipeline, n being the active section count (1 to 5); a new
// request is taken only after the previous result is in the result register.
// Synchronous active-low reset zeroes all history and selects mode 0.
module cascaded_biquad_lowpass_core #(
    parameter int MAX_SECTIONS = 5,
    parameter int DATA_WIDTH   = 24,
    parameter int COEF_WIDTH   = 24
) (
    input logic        i_clk,
    input logic        i_rst_n,
    cbq_cfg_if.sink    i_cfg,
    cbq_in_if.sink     i_sample,
    cbq_out_if.source  o_result
);
    import cbq_pkg::*;

    logic [MODE_W-1:0] r_mode;
    t_ctrl             ctrl;
    t_status           status;

    // Mode register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0;
        end else if (i_cfg.valid) begin
            r_mode <= i_cfg.data;
        end
    end

    cbq_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .i_in_clear (i_sample.kind),
        .i_status   (status),
        .o_ctrl     (ctrl),
        .o_in_ready (i_sample.ready)
    );

    cbq_datapath #(
        .MAX_SECTIONS (MAX_SECTIONS),
        .DATA_WIDTH   (DATA_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_mode      (r_mode),
        .i_sample    (i_sample.sample_in),
        .i_out_ready (o_result.ready),
        .o_status    (status),
        .o_out_valid (o_result.valid),
        .o_filtered  (o_result.filtered),
        .o_saturated (o_result.saturated)
    );

endmodule

// ----- test/cascaded_biquad_lowpass_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the cascaded biquad low-pass core: filter and clear requests
// are checked against a bit-exact predictor of every coefficient set. Needs cbq_pkg,
// the cbq_*_if channels and cascaded_biquad_lowpass_core.
module cascaded_biquad_lowpass_core_tb;
    import cbq_pkg::*;

    localparam int DATA_W        = 24;
    localparam int COEF_W        = 24;
    localparam int N_SECTIONS    = 5;
    localparam int COEF_FRAC     = COEF_W - 2;
    localparam int RANDOM_ITEMS  = 650;
    localparam int SETTLE_CYCLES = 50;
    localparam int LIMIT_CYCLES  = 400000;

    localparam logic KIND_FILTER = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    // Coefficient set codes; the top three codes alias the MODE_LP200 set
    localparam logic [MODE_W-1:0] MODE_LP80     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ORDER2   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LP60     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LP500    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LP200    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ALIAS_A  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_ALIAS_B  = 3'd6;
    localparam logic [MODE_W-1:0] MODE_ALIAS_C  = 3'd7;

    localparam logic signed [DATA_W-1:0] SAMPLE_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAMPLE_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam longint SECTION_MAX = 64'sd2147483647;
    localparam longint SECTION_MIN = -SECTION_MAX - 1;
    localparam longint DATA_MAX    = (64'sd1 <<< (DATA_W - 1)) - 1;
    localparam longint DATA_MIN    = -DATA_MAX - 1;

    typedef struct {
        logic signed [DATA_W-1:0] filtered;
        logic                     saturated;
    } t_filter_out;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cbq_in_if  #(.DATA_WIDTH(DATA_W)) sample_if ();
    cbq_out_if #(.DATA_WIDTH(DATA_W)) result_if ();
    cbq_cfg_if                        mode_if ();

    cascaded_biquad_lowpass_core #(
        .MAX_SECTIONS (N_SECTIONS),
        .DATA_WIDTH   (DATA_W),
        .COEF_WIDTH   (COEF_W)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (mode_if),
        .i_sample (sample_if),
        .o_result (result_if)
    );

    // Predictor state: two past samples, two past outputs per section, mode shadow
    longint            past_samples [2];
    longint            section_outs [2*N_SECTIONS];
    logic [MODE_W-1:0] mode_shadow;

    t_filter_out expected_outputs [$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          steady      = 1'b0;
    bit          offering    = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Work out the result of one request and advance the predictor state
    function automatic t_filter_out run_cascade(input logic kind,
                                                input logic signed [DATA_W-1:0] smp);
        t_filter_out       r;
        longint            u0, u1, u2, h1, h2, acc, y, last;
        int                n;
        logic [MODE_W-1:0] m;
        r.filtered  = '0;
        r.saturated = 1'b0;
        if (kind == KIND_CLEAR) begin
            foreach (past_samples[i]) past_samples[i] = 0;
            foreach (section_outs[i]) section_outs[i] = 0;
            return r;
        end
        u0 = longint'(smp);
        u1 = past_samples[0];
        u2 = past_samples[1];
        past_samples[1] = past_samples[0];
        past_samples[0] = u0;
        m = (mode_shadow > MODE_MAX) ? MODE_MAX : mode_shadow;
        n = int'(SECTION_COUNT[m]);
        if (n > N_SECTIONS) n = N_SECTIONS;
        last = 0;
        for (int k = 0; k < n; k++) begin
            h1 = section_outs[2*k];
            h2 = section_outs[2*k+1];
            acc = longint'(COEF_TABLE[m][k][0]) * u0
                + longint'(COEF_TABLE[m][k][1]) * u1
                + longint'(COEF_TABLE[m][k][2]) * u2
                - longint'(COEF_TABLE[m][k][3]) * h1
                - longint'(COEF_TABLE[m][k][4]) * h2;
            acc = acc + (64'sd1 <<< (COEF_FRAC - 1));
            y = acc >>> COEF_FRAC;
            if (y > SECTION_MAX) y = SECTION_MAX;
            if (y < SECTION_MIN) y = SECTION_MIN;
            section_outs[2*k+1] = h1;
            section_outs[2*k]   = y;
            u0 = y;
            u1 = h1;
            u2 = h2;
            last = y;
        end
        if (last > DATA_MAX) begin
            r.filtered  = SAMPLE_MAX;
            r.saturated = 1'b1;
        end else if (last < DATA_MIN) begin
            r.filtered  = SAMPLE_MIN;
            r.saturated = 1'b1;
        end else begin
            r.filtered = last[DATA_W-1:0];
        end
        return r;
    endfunction

    // Result side: random stalls, compare each result with the oldest prediction
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_filter_out want;
        int          n;
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
            stall_left = 0;
        end else if (result_if.valid && result_if.ready) begin
            if (expected_outputs.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual filtered %0d sat %0b",
                         $realtime, result_if.filtered, result_if.saturated);
                error_count++;
            end else begin
                want = expected_outputs.pop_front();
                if (result_if.filtered !== want.filtered) begin
                    $display("%0t: filtered mismatch: expected %0d, actual %0d",
                             $realtime, want.filtered, result_if.filtered);
                    error_count++;
                end
                if (result_if.saturated !== want.saturated) begin
                    $display("%0t: saturated mismatch: expected %0b, actual %0b",
                             $realtime, want.saturated, result_if.saturated);
                    error_count++;
                end
            end
            n = steady ? 0 : $urandom_range(0, 15);
            if (n != 0) begin
                result_if.ready <= 1'b0;
                stall_left = n;
            end
        end else if (!result_if.ready) begin
            if (stall_left > 0) stall_left--;
            if (stall_left == 0) result_if.ready <= 1'b1;
        end
    end

    // Offer one request after a random gap and record its prediction on acceptance
    task automatic send_request(input logic kind, input logic signed [DATA_W-1:0] smp);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 15);
        if (gap != 0 && offering) begin
            sample_if.valid <= 1'b0;
            offering = 1'b0;
        end
        repeat (gap) @(posedge i_clk);
        sample_if.valid     <= 1'b1;
        sample_if.kind      <= kind;
        sample_if.sample_in <= smp;
        offering = 1'b1;
        do @(posedge i_clk); while (!sample_if.ready);
        expected_outputs.push_back(run_cascade(kind, smp));
    endtask

    // Withdraw the request line and wait until every prediction is answered
    task automatic drain_requests;
        if (offering) begin
            sample_if.valid <= 1'b0;
            offering = 1'b0;
        end
        while (expected_outputs.size() != 0) @(posedge i_clk);
    endtask

    // Write the mode register once the core is idle
    task automatic write_mode(input logic [MODE_W-1:0] m);
        drain_requests();
        mode_if.valid <= 1'b1;
        mode_if.data  <= m;
        do @(posedge i_clk); while (!mode_if.ready);
        mode_if.valid <= 1'b0;
        mode_shadow = m;
    endtask

    function automatic logic signed [DATA_W-1:0] any_sample();
        return DATA_W'($urandom());
    endfunction

    // Mode 0 straight out of reset, field extremes
    task automatic test_reset_defaults;
        send_request(KIND_FILTER, SAMPLE_MAX);
        send_request(KIND_FILTER, SAMPLE_MAX);
        send_request(KIND_FILTER, SAMPLE_MIN);
        send_request(KIND_FILTER, '0);
    endtask

    // Clear requests ignore the sample and zero all history
    task automatic test_clear_requests;
        send_request(KIND_CLEAR, SAMPLE_MAX);
        send_request(KIND_FILTER, 24'sd1);
        send_request(KIND_CLEAR, SAMPLE_MIN);
        send_request(KIND_FILTER, -24'sd1);
    endtask

    // Every mode code but MODE_LP80, aliases included; unused sections keep their history
    task automatic test_mode_sweep;
        logic [MODE_W-1:0] order [8];
        order = '{MODE_LP500, MODE_ORDER2, MODE_LP60, MODE_LP500, MODE_LP200,
                  MODE_ALIAS_A, MODE_ALIAS_B, MODE_ALIAS_C};
        foreach (order[i]) begin
            write_mode(order[i]);
            send_request(KIND_FILTER, any_sample());
        end
    endtask

    // Full-scale steps through five sections to drive the output clip
    task automatic test_saturation;
        write_mode(MODE_LP500);
        repeat (4) send_request(KIND_FILTER, SAMPLE_MAX);
        repeat (4) send_request(KIND_FILTER, SAMPLE_MIN);
    endtask

    // Phases of random mode, each a run of steps, noise, ramps and sparse clears
    task automatic test_random_traffic;
        int  sent, phase_len, seg_len, style, i, j;
        int  level, value, slope;
        bit  paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            write_mode(MODE_W'($urandom_range(0, 7)));
            steady    = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(20, 60);
            i = 0;
            while (i < phase_len && sent < RANDOM_ITEMS) begin
                style   = $urandom_range(0, 3);
                seg_len = $urandom_range(3, 20);
                case ($urandom_range(0, 3))
                    0:       level = int'(DATA_MAX);
                    1:       level = int'(DATA_MIN);
                    default: level = int'(any_sample());
                endcase
                slope = $urandom_range(0, 200000) - 100000;
                for (j = 0; j < seg_len && sent < RANDOM_ITEMS; j++) begin
                    case (style)
                        0:       value = level;
                        1:       value = int'(any_sample());
                        2:       value = level + $urandom_range(0, 2000) - 1000;
                        default: value = level + j * slope;
                    endcase
                    if (value > DATA_MAX) value = int'(DATA_MAX);
                    if (value < DATA_MIN) value = int'(DATA_MIN);
                    if ($urandom_range(0, 39) == 0)
                        send_request(KIND_CLEAR, any_sample());
                    else
                        send_request(KIND_FILTER, DATA_W'(value));
                    sent++;
                    i++;
                end
            end
            // Hold the sender once until the result queue runs dry
            if (!paused && sent > RANDOM_ITEMS / 2) begin
                drain_requests();
                paused = 1'b1;
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        sample_if.valid     <= 1'b0;
        sample_if.kind      <= KIND_FILTER;
        sample_if.sample_in <= '0;
        mode_if.valid       <= 1'b0;
        mode_if.data        <= MODE_LP80;
        foreach (past_samples[i]) past_samples[i] = 0;
        foreach (section_outs[i]) section_outs[i] = 0;
        mode_shadow = MODE_LP80;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_clear_requests();
        test_mode_sweep();
        test_saturation();
        test_random_traffic();

        drain_requests();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- cascaded_biquad_lowpass_core.f -----
rtl/cbq_pkg.sv
rtl/cbq_if.sv
rtl/cbq_seq.sv
rtl/cbq_datapath.sv
rtl/cascaded_biquad_lowpass_core.sv
test/cascaded_biquad_lowpass_core_tb.sv
